[hdl/tcs_pkg.sv]
// Shared constants, types and helpers of the triangle transform, cull and shade block.
package tcs_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 240;
  localparam int SHADE_STEPS   = 13;

  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  // Signed width that holds the screen size.
  localparam int SZ_W  = $clog2(SIZE_MAX + 1) + 1;
  localparam int T_W   = 34;
  localparam int NUM_W = T_W + SZ_W;
  localparam int NW    = NUM_W - 15;
  localparam int RW    = (NW > 33) ? NW : 33;

  localparam int XF_STAGES  = 4;
  localparam int DIV_STAGES = 9;
  localparam int DIV_FIRST  = 7;
  localparam int NSTAGE     = DIV_FIRST + DIV_STAGES + 1;
  localparam int NLANE      = 6;

  localparam logic [2:0] REG_COS_Z   = 3'd0;
  localparam logic [2:0] REG_SIN_Z   = 3'd1;
  localparam logic [2:0] REG_COS_X   = 3'd2;
  localparam logic [2:0] REG_SIN_X   = 3'd3;
  localparam logic [2:0] REG_Z_OFF   = 3'd4;
  localparam logic [2:0] REG_PROJ_X  = 3'd5;
  localparam logic [2:0] REG_PROJ_Y  = 3'd6;

  typedef struct packed {
    logic signed [15:0] cos_z;
    logic signed [15:0] sin_z;
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_x;
    logic signed [15:0] z_offset;
  } rot_cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] res;
    if (v > 64'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

[hdl/tcs_xform.sv]
// Pipelined rotation of one vertex about Z and then X, rounded back to Q8.8.
module tcs_xform import tcs_pkg::*; (
  input  logic                 clk,
  input  logic [XF_STAGES-1:0] en,
  input  rot_cfg_t             cfg,
  input  logic signed [15:0]   x,
  input  logic signed [15:0]   y,
  input  logic signed [15:0]   z,
  output logic signed [15:0]   xo,
  output logic signed [15:0]   yo,
  output logic signed [15:0]   zo
);

  logic signed [31:0] xcz_r, ysz_r, xsz_r, ycz_r, zsx0_r, zcx0_r;
  logic signed [32:0] yr_r;
  logic signed [31:0] zsx1_r, zcx1_r, zsx2_r, zcx2_r;
  logic signed [15:0] x1_r, x2_r, xo_r, yo_r, zo_r;
  logic signed [48:0] ycx_r, ysx_r;
  logic signed [32:0] xr;

  assign xr = 33'(xcz_r) - 33'(ysz_r);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xcz_r  <= 32'(x) * 32'(cfg.cos_z);
      ysz_r  <= 32'(y) * 32'(cfg.sin_z);
      xsz_r  <= 32'(x) * 32'(cfg.sin_z);
      ycz_r  <= 32'(y) * 32'(cfg.cos_z);
      zsx0_r <= 32'(z) * 32'(cfg.sin_x);
      zcx0_r <= 32'(z) * 32'(cfg.cos_x);
    end
    if (en[1]) begin
      x1_r   <= sat16((64'(xr) + 64'sd8192) >>> 14);
      yr_r   <= 33'(xsz_r) + 33'(ycz_r);
      zsx1_r <= zsx0_r;
      zcx1_r <= zcx0_r;
    end
    if (en[2]) begin
      ycx_r  <= 49'(yr_r) * 49'(cfg.cos_x);
      ysx_r  <= 49'(yr_r) * 49'(cfg.sin_x);
      zsx2_r <= zsx1_r;
      zcx2_r <= zcx1_r;
      x2_r   <= x1_r;
    end
    if (en[3]) begin
      xo_r <= x2_r;
      // Round half up at the Q8.8 point, then saturate.
      yo_r <= sat16((64'(ycx_r) - (64'(zsx2_r) <<< 14) + 64'sd134217728) >>> 28);
      zo_r <= sat16((64'(ysx_r) + (64'(zcx2_r) <<< 14) + (64'(cfg.z_offset) <<< 28)
                     + 64'sd134217728) >>> 28);
    end
  end

  assign xo = xo_r;
  assign yo = yo_r;
  assign zo = zo_r;

endmodule

[hdl/tcs_div.sv]
// Pipelined restoring divider, two quotient bits per stage after the loading stage, with signed 16-bit saturation.
module tcs_div import tcs_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NW-1:0]         num,
  input  logic [15:0]           den,
  input  logic                  neg,
  output logic signed [15:0]    q
);

  localparam int LAST = DIV_STAGES - 1;

  logic [RW-1:0] r_r   [DIV_STAGES];
  logic [15:0]   d_r   [DIV_STAGES];
  logic [15:0]   q_r   [DIV_STAGES];
  logic          ovf_r [DIV_STAGES];
  logic          neg_r [DIV_STAGES];
  logic [15:0]   qm;

  function automatic logic [RW+1:0] step2(input logic [RW-1:0] r, input logic [15:0] d,
                                          input int b);
    logic [RW-1:0] dh, dl, r1, r2;
    logic          b1, b0;
    dh = RW'(d) << b;
    dl = RW'(d) << (b - 1);
    b1 = (r >= dh);
    r1 = b1 ? (r - dh) : r;
    b0 = (r1 >= dl);
    r2 = b0 ? (r1 - dl) : r1;
    return {b1, b0, r2};
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]   <= RW'(num);
      d_r[0]   <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      // A quotient of 2^16 or more saturates whatever the sign.
      ovf_r[0] <= (RW'(num) >= (RW'(den) << 16));
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (en[j]) begin
        logic [RW+1:0] st;
        st       = step2(r_r[j-1], d_r[j-1], 17 - 2 * j);
        r_r[j]   <= st[RW-1:0];
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= q_r[j-1] | (16'(st[RW+1:RW]) << (16 - 2 * j));
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  always_comb begin
    qm = q_r[LAST];
    if (!neg_r[LAST]) begin
      q = (ovf_r[LAST] || qm[15]) ? 16'sh7fff : $signed(qm);
    end else begin
      q = (ovf_r[LAST] || (qm[15] && (qm[14:0] != 15'd0))) ? 16'sh8000
                                                           : $signed(16'(~qm + 16'd1));
    end
  end

endmodule

[hdl/triangle_transform_cull_shade.sv]
// Top level: triangle rotation, back-face cull, flat shade and screen projection pipeline.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in_     | slave     | in_tvalid / in_tready    | in_tdata: v0_x..v2_z, 16 bits each
//  out_    | master    | out_tvalid / out_tready  | out_tuser: visible; out_tdata: s0_x..s2_y,
//          |           |                          |   shade_level
//  cfg_    | slave     | cfg_valid / cfg_ready    | cfg_addr register index, cfg_data value
//
// One triangle enters per cycle while in_tready is high; each result passes through
// 7 stages of rotation and setup, then the 9-stage divider and the output stage.
// Every stage holds only while the stage after it is full and stalled, so bubbles
// close up and a stalled output still lets requests in. Synchronous active-low
// reset clears the stage valid bits and loads the register defaults.
module triangle_transform_cull_shade import tcs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // s0_x, s0_y, s1_x, s1_y, s2_x, s2_y, shade_level, pad
  output logic [0:0]   out_tuser,  // visible
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_data
);

  localparam int OUT_ST = NSTAGE - 1;

  rot_cfg_t     rot_cfg_r;
  logic [15:0]  proj_x_r, proj_y_r;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic signed [15:0] vz [3];

  // Setup stages.
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [15:0] v0_4_r [3];
  logic signed [15:0] v0_5_r [3];
  logic signed [15:0] v0_6_r [3];
  logic signed [33:0] p_r [6];
  logic signed [34:0] n_r [3];
  logic signed [50:0] dp_r [3];
  logic [33:0]        hh_r [3];
  logic [33:0]        hl_r [3];
  logic [33:0]        ll_r [3];
  logic               nzneg7_r, nzneg8_r, nzneg9_r, nzneg10_r;
  logic [67:0]        sq_r [3];
  logic [69:0]        nn_r;
  logic [67:0]        nz2_r;
  logic [77:0]        kn_r [1:SHADE_STEPS];
  logic [77:0]        rz_r;
  logic               vis_r [8:OUT_ST-1];
  logic [3:0]         lvl_r [11:OUT_ST-1];

  // Projection lanes: s0_x, s0_y, s1_x, s1_y, s2_x, s2_y.
  logic signed [15:0]      lane_c  [NLANE];
  logic signed [15:0]      lane_z  [NLANE];
  logic [15:0]             lane_sc [NLANE];
  logic signed [32:0]      cs_r    [NLANE];
  logic signed [15:0]      ze4_r   [NLANE];
  logic signed [15:0]      ze5_r   [NLANE];
  logic signed [15:0]      ze6_r   [NLANE];
  logic signed [T_W-1:0]   t_r     [NLANE];
  logic signed [NUM_W-1:0] num_r   [NLANE];
  logic [NW-1:0]           dnum    [NLANE];
  logic [15:0]             dden    [NLANE];
  logic                    dneg    [NLANE];
  logic signed [15:0]      q       [NLANE];

  logic               out_vis_r;
  logic signed [15:0] out_s_r [NLANE];
  logic [3:0]         out_lvl_r;

  logic signed [52:0] dot;
  logic [SHADE_STEPS:1] cmp;
  logic [3:0]         lvl;

  // Configuration registers: written by user only while no request is in flight; unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cfg_r.cos_z    <= 16'sd16384;
      rot_cfg_r.sin_z    <= 16'sd0;
      rot_cfg_r.cos_x    <= 16'sd16384;
      rot_cfg_r.sin_x    <= 16'sd0;
      rot_cfg_r.z_offset <= 16'sd768;
      proj_x_r           <= 16'd15360;
      proj_y_r           <= 16'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_COS_Z:  rot_cfg_r.cos_z    <= cfg_data;
        REG_SIN_Z:  rot_cfg_r.sin_z    <= cfg_data;
        REG_COS_X:  rot_cfg_r.cos_x    <= cfg_data;
        REG_SIN_X:  rot_cfg_r.sin_x    <= cfg_data;
        REG_Z_OFF:  rot_cfg_r.z_offset <= cfg_data;
        REG_PROJ_X: proj_x_r           <= cfg_data;
        REG_PROJ_Y: proj_y_r           <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the next one moves.
  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_xf
    tcs_xform u_xf (
      .clk (clk),
      .en  (en[XF_STAGES-1:0]),
      .cfg (rot_cfg_r),
      .x   ($signed(in_tdata[48*i +: 16])),
      .y   ($signed(in_tdata[48*i + 16 +: 16])),
      .z   ($signed(in_tdata[48*i + 32 +: 16])),
      .xo  (vx[i]),
      .yo  (vy[i]),
      .zo  (vz[i])
    );
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      lane_c[l]  = (l % 2 == 1) ? vy[l/2] : vx[l/2];
      lane_z[l]  = vz[l/2];
      lane_sc[l] = (l % 2 == 1) ? proj_y_r : proj_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e1_r[0] <= 17'(vx[1]) - 17'(vx[0]);
      e1_r[1] <= 17'(vy[1]) - 17'(vy[0]);
      e1_r[2] <= 17'(vz[1]) - 17'(vz[0]);
      e2_r[0] <= 17'(vx[2]) - 17'(vx[0]);
      e2_r[1] <= 17'(vy[2]) - 17'(vy[0]);
      e2_r[2] <= 17'(vz[2]) - 17'(vz[0]);
      v0_4_r[0] <= vx[0];
      v0_4_r[1] <= vy[0];
      v0_4_r[2] <= vz[0];
      for (int l = 0; l < NLANE; l++) begin
        cs_r[l] <= 33'(lane_c[l]) * $signed(33'(lane_sc[l]));
        // A vertex at depth zero projects as if its depth divisor were 2^8.
        ze4_r[l] <= (lane_z[l] == 16'sd0) ? 16'sd256 : lane_z[l];
      end
    end
    if (en[5]) begin
      p_r[0] <= 34'(e1_r[1]) * 34'(e2_r[2]);
      p_r[1] <= 34'(e1_r[2]) * 34'(e2_r[1]);
      p_r[2] <= 34'(e1_r[2]) * 34'(e2_r[0]);
      p_r[3] <= 34'(e1_r[0]) * 34'(e2_r[2]);
      p_r[4] <= 34'(e1_r[0]) * 34'(e2_r[1]);
      p_r[5] <= 34'(e1_r[1]) * 34'(e2_r[0]);
      v0_5_r <= v0_4_r;
      for (int l = 0; l < NLANE; l++) begin
        t_r[l]   <= T_W'(cs_r[l]) + (T_W'(ze4_r[l]) <<< 14);
        ze5_r[l] <= ze4_r[l];
      end
    end
    if (en[6]) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= 35'(p_r[2*k]) - 35'(p_r[2*k+1]);
      end
      v0_6_r <= v0_5_r;
      for (int l = 0; l < NLANE; l++) begin
        num_r[l] <= NUM_W'(t_r[l])
                    * ((l % 2 == 1) ? NUM_W'(SCREEN_HEIGHT) : NUM_W'(SCREEN_WIDTH));
        ze6_r[l] <= ze5_r[l];
      end
    end
    if (en[7]) begin
      for (int k = 0; k < 3; k++) begin
        logic [34:0] a;
        a = n_r[k][34] ? 35'(-n_r[k]) : 35'(n_r[k]);
        dp_r[k] <= 51'(n_r[k]) * 51'(v0_6_r[k]);
        hh_r[k] <= 34'(a[33:17]) * 34'(a[33:17]);
        hl_r[k] <= 34'(a[33:17]) * 34'(a[16:0]);
        ll_r[k] <= 34'(a[16:0]) * 34'(a[16:0]);
      end
      nzneg7_r <= n_r[2][34];
    end
    if (en[8]) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (68'(hh_r[k]) << 34) + (68'(hl_r[k]) << 18) + 68'(ll_r[k]);
      end
      vis_r[8] <= dot[52];
      nzneg8_r <= nzneg7_r;
    end
    if (en[9]) begin
      nn_r     <= 70'(sq_r[0]) + 70'(sq_r[1]) + 70'(sq_r[2]);
      nz2_r    <= sq_r[2];
      nzneg9_r <= nzneg8_r;
    end
    if (en[10]) begin
      // Level k holds while k^2 * |n|^2 <= 13^2 * nz^2.
      for (int k = 1; k <= SHADE_STEPS; k++) begin
        kn_r[k] <= 78'(nn_r) * 78'(k * k);
      end
      rz_r      <= 78'(nz2_r) * 78'(SHADE_STEPS * SHADE_STEPS);
      nzneg10_r <= nzneg9_r;
    end
    if (en[11]) begin
      lvl_r[11] <= lvl;
    end
    for (int i = 9; i < OUT_ST; i++) begin
      if (en[i]) begin
        vis_r[i] <= vis_r[i-1];
      end
    end
    for (int i = 12; i < OUT_ST; i++) begin
      if (en[i]) begin
        lvl_r[i] <= lvl_r[i-1];
      end
    end
    if (en[OUT_ST]) begin
      out_vis_r <= vis_r[OUT_ST-1];
      out_lvl_r <= vis_r[OUT_ST-1] ? lvl_r[OUT_ST-1] : 4'd0;
      for (int l = 0; l < NLANE; l++) begin
        out_s_r[l] <= vis_r[OUT_ST-1] ? q[l] : 16'sd0;
      end
    end
  end

  assign dot = 53'(dp_r[0]) + 53'(dp_r[1]) + 53'(dp_r[2]);

  always_comb begin
    for (int k = 1; k <= SHADE_STEPS; k++) begin
      cmp[k] = (kn_r[k] <= rz_r);
    end
    lvl = 4'd0;
    // The prefix of satisfied levels is contiguous; a normal straight along -z gives 0.
    if (nzneg10_r && !cmp[SHADE_STEPS]) begin
      for (int k = 1; k < SHADE_STEPS; k++) begin
        if (cmp[k]) begin
          lvl = 4'(k);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic [NUM_W-1:0] m;
      m       = num_r[l][NUM_W-1] ? NUM_W'(-num_r[l]) : NUM_W'(num_r[l]);
      dnum[l] = m[NUM_W-1:15];
      dden[l] = ze6_r[l][15] ? 16'(-ze6_r[l]) : 16'(ze6_r[l]);
      dneg[l] = num_r[l][NUM_W-1] ^ ze6_r[l][15];
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_div
    tcs_div u_div (
      .clk (clk),
      .en  (en[DIV_FIRST +: DIV_STAGES]),
      .num (dnum[l]),
      .den (dden[l]),
      .neg (dneg[l]),
      .q   (q[l])
    );
  end

  assign out_tvalid = vld_r[OUT_ST];
  assign out_tuser  = out_vis_r;
  assign out_tdata  = {4'd0, out_lvl_r, out_s_r[5], out_s_r[4], out_s_r[3], out_s_r[2],
                       out_s_r[1], out_s_r[0]};

endmodule

[hdl/tcs_checker.sv]
// Port-level checks of the triangle pipeline, bound to the top level.
module tcs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // A culled triangle carries no coordinates and no shade.
  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 104'd0)
    else $error("culled result carries nonzero payload");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[99:96] <= 4'd12 && out_tdata[103:100] == 4'd0)
    else $error("shade level out of range or padding set");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind triangle_transform_cull_shade tcs_checker u_tcs_checker (.*);

[tb/triangle_transform_cull_shade_tb.sv]
// Self-checking testbench for the triangle transform, cull and shade pipeline.
module triangle_transform_cull_shade_tb;
  import tcs_pkg::*;

  typedef struct {
    bit         visible;
    bit [103:0] pixels;
  } screen_tri_t;

  class screen_tri_scoreboard;
    bit [15:0]   regs[7];
    screen_tri_t screen_tri_q[$];
    int          mismatches;
    int          checked;
    int          shown_visible;

    function new();
      regs = '{16'd16384, 16'd0, 16'd16384, 16'd0, 16'd768, 16'd15360, 16'd16384};
    endfunction

    function void write_reg(bit [2:0] idx, bit [15:0] val);
      if (idx < 7) regs[idx] = val;
    endfunction

    function longint to_q8_8(longint a);
      longint t;
      t = (a + (64'sd1 <<< 27)) >>> 28;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    function longint to_pixel(longint c, longint z, longint scale, longint size);
      longint q;
      if (z != 0) q = ((c * scale + z * 16384) * size) / (z * 32768);
      else q = ((c * scale + 4194304) * size) / 8388608;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    function bit [3:0] shade_of(longint nx, longint ny, longint nz);
      bit [127:0] ax, ay, az, sum, rhs;
      int k;
      if (nz >= 0) return 0;
      ax = (nx < 0) ? -nx : nx;
      ay = (ny < 0) ? -ny : ny;
      az = -nz;
      sum = ax * ax + ay * ay + az * az;
      rhs = 128'd169 * az * az;
      for (k = SHADE_STEPS; k > 0; k--) begin
        if (k * k * sum <= rhs) break;
      end
      return (k >= SHADE_STEPS) ? 4'd0 : k[3:0];
    endfunction

    // Rotates, culls, shades and projects one triangle request.
    function void project_triangle(bit [143:0] d);
      longint v[3][3], e1[3], e2[3], n[3], dot, x, y, z, xr, yr, cz, sz, cx, sx, zo;
      screen_tri_t r;
      cz = longint'(signed'(regs[REG_COS_Z]));
      sz = longint'(signed'(regs[REG_SIN_Z]));
      cx = longint'(signed'(regs[REG_COS_X]));
      sx = longint'(signed'(regs[REG_SIN_X]));
      zo = longint'(signed'(regs[REG_Z_OFF]));
      for (int i = 0; i < 3; i++) begin
        x = longint'(signed'(d[i*48 +: 16]));
        y = longint'(signed'(d[i*48+16 +: 16]));
        z = longint'(signed'(d[i*48+32 +: 16])) * 16384;
        xr = x * cz - y * sz;
        yr = x * sz + y * cz;
        v[i][0] = to_q8_8(xr * 16384);
        v[i][1] = to_q8_8(yr * cx - z * sx);
        v[i][2] = to_q8_8(yr * sx + z * cx + zo * 268435456);
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] = v[1][i] - v[0][i];
        e2[i] = v[2][i] - v[0][i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      dot = n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2];
      r.visible = 0;
      r.pixels = '0;
      if (dot < 0) begin
        r.visible = 1;
        for (int i = 0; i < 3; i++) begin
          r.pixels[i*32 +: 16] = 16'(to_pixel(v[i][0], v[i][2],
                                 longint'({48'd0, regs[REG_PROJ_X]}), SCREEN_WIDTH));
          r.pixels[i*32+16 +: 16] = 16'(to_pixel(v[i][1], v[i][2],
                                    longint'({48'd0, regs[REG_PROJ_Y]}), SCREEN_HEIGHT));
        end
        r.pixels[99:96] = shade_of(n[0], n[1], n[2]);
      end
      screen_tri_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(bit vis, bit [103:0] px);
      screen_tri_t e;
      string names[7] = '{"s0_x", "s0_y", "s1_x", "s1_y", "s2_x", "s2_y", "shade_level"};
      if (screen_tri_q.size() == 0) begin
        report("result with no triangle outstanding");
        return;
      end
      e = screen_tri_q.pop_front();
      checked++;
      if (vis) shown_visible++;
      if (vis != e.visible)
        report($sformatf("visible got %0d want %0d", vis, e.visible));
      for (int i = 0; i < 6; i++)
        if (px[i*16 +: 16] != e.pixels[i*16 +: 16])
          report($sformatf("%s got %0d want %0d", names[i],
                 $signed(px[i*16 +: 16]), $signed(e.pixels[i*16 +: 16])));
      if (px[99:96] != e.pixels[99:96])
        report($sformatf("%s got %0d want %0d", names[6], px[99:96], e.pixels[99:96]));
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_addr;
  logic [15:0]  cfg_data;

  screen_tri_scoreboard sb = new();
  int  stall_pct = 30;
  bit  hold_req;
  int  hold_cnt;
  bit  no_gaps;
  int  sent;

  triangle_transform_cull_shade DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.project_triangle(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  // Output back-pressure; a long hold-off is counted down here.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic bit [143:0] mk(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    return {16'(c2), 16'(c1), 16'(c0), 16'(b2), 16'(b1), 16'(b0), 16'(a2), 16'(a1), 16'(a0)};
  endfunction

  task automatic send_tri(bit [143:0] d);
    int r, gap;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.screen_tri_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [15:0] val);
    cfg_addr  <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_view(int cz, sz, cx, sx, zo, px, py);
    write_reg(REG_COS_Z, 16'(cz));
    write_reg(REG_SIN_Z, 16'(sz));
    write_reg(REG_COS_X, 16'(cx));
    write_reg(REG_SIN_X, 16'(sx));
    write_reg(REG_Z_OFF, 16'(zo));
    write_reg(REG_PROJ_X, 16'(px));
    write_reg(REG_PROJ_Y, 16'(py));
  endtask

  // Mostly small triangles near the camera so that many are visible.
  function automatic bit [143:0] rand_tri();
    bit [143:0] d;
    int lim;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom);
    end else begin
      lim = $urandom_range(0, 1) ? 600 : 2000;
      for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom_range(0, 2 * lim) - lim);
    end
    return d;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) send_tri(rand_tri());
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed triangles under the reset view.
    send_tri(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_tri(mk(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
    send_tri(mk(32767, -32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767));
    // Flat triangle facing straight at the light, then its culled twin.
    send_tri(mk(0, 0, 0, 0, 256, 0, 256, 0, 0));
    send_tri(mk(0, 0, 0, 256, 0, 0, 0, 256, 0));
    // Tilted faces for intermediate shade levels.
    send_tri(mk(0, 0, 0, 0, 256, 100, 256, 0, 0));
    send_tri(mk(0, 0, 0, 0, 256, 300, 256, 0, -50));
    send_tri(mk(-100, -100, 200, 0, 256, 900, 256, 0, 20));
    send_tri(mk(0, 0, 0, 0, 256, -2000, 256, 0, 0));
    // Vertices at depth zero after the offset.
    send_tri(mk(0, 0, -768, 0, 256, 0, 256, 0, 0));
    send_tri(mk(100, 50, -768, 0, 256, -768, 256, 0, -768));
    send_tri(mk(10, 10, -700, 0, 256, -768, 256, 0, -1000));
    // Degenerate: collinear and coincident vertices, then an extreme and a tiny triangle.
    send_tri(mk(100, 100, 100, 200, 200, 200, 300, 300, 300));
    send_tri(mk(5, 6, 7, 5, 6, 7, 5, 6, 7));
    send_tri(mk(-32768, 32767, -768, 32767, -32768, -768, 0, 0, -32768));
    send_tri(mk(1, 1, 1, -1, -1, -1, 1, -1, 1));
    drain();

    no_gaps = 1;
    stall_pct = 0;
    random_run(150);
    no_gaps = 0;
    stall_pct = 30;
    random_run(150);
    drain();

    set_view(-16384, 16384, 16384, -16384, -32768, 0, 65535);
    write_reg(3'd7, 16'hbeef);
    random_run(100);
    drain();

    set_view(16384, -16384, -16384, 16384, 32767, 65535, 0);
    random_run(100);
    drain();

    // Fill the pipeline against a stalled output.
    set_view(11585, 11585, 14189, 8192, 1024, 15360, 16384);
    hold_req = 1;
    no_gaps = 1;
    random_run(80);
    no_gaps = 0;
    drain();

    for (int p = 0; p < 4; p++) begin
      set_view($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
               $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
               (p == 3) ? $urandom : $urandom_range(256, 2048), $urandom, $urandom);
      stall_pct = (p == 1) ? 80 : 30;
      random_run(130);
      drain();
    end

    // Return to the reset view values.
    set_view(16384, 0, 16384, 0, 768, 15360, 16384);
    random_run(50);
    drain();

    $display("%0d triangles sent over 9 view settings, %0d results checked, %0d visible",
             sent, sb.checked, sb.shown_visible);
    $display("views covered rotation and projection extremes and a stalled-output fill");
    if (sb.mismatches == 0) begin
      $display("triangle_transform_cull_shade_tb OK");
    end else begin
      $display("triangle_transform_cull_shade_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.screen_tri_q.size());
    $display("triangle_transform_cull_shade_tb NOT OK");
    $finish;
  end

endmodule
